// ===== sv/olist_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ordered list engine.
// No dependencies; used by olist_cell and ordered_list_engine_core.
package olist_pkg;

  localparam int DATA_W          = 32;
  localparam int REQ_W           = 2;
  localparam int STAT_W          = 2;
  localparam int LEN_W           = 5;
  localparam int DEF_MAX_ENTRIES = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_REMOVE     = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } state_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic match_en;          // capture entry == key
    logic load_tail;         // write key into the cell at the tail
    logic shift_right;       // take left neighbor (push front)
    logic shift_left_all;    // take right neighbor (pop front)
    logic shift_left_found;  // take right neighbor at and after the first match
  } cell_cmd_t;

endpackage

// ===== sv/olist_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list: holds one entry and its match flag.
// Depends on olist_pkg.
module olist_cell (
  input  logic                                 clk,
  input  olist_pkg::cell_cmd_t                 cmd,
  input  logic        [olist_pkg::DATA_W-1:0]  key,
  input  logic        [olist_pkg::DATA_W-1:0]  left_entry,
  input  logic        [olist_pkg::DATA_W-1:0]  right_entry,
  input  logic                                 occupied,
  input  logic                                 is_tail,
  input  logic                                 found_in,
  output logic                                 found_out,
  output logic        [olist_pkg::DATA_W-1:0]  entry
);

  logic match;

  // Found at this cell or at any cell nearer the front.
  assign found_out = found_in | match;

  always_ff @(posedge clk) begin
    if (cmd.match_en) begin
      match <= occupied && (entry == key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tail && is_tail) begin
      entry <= key;
    end else if (cmd.shift_right) begin
      entry <= left_entry;
    end else if (cmd.shift_left_all || (cmd.shift_left_found && found_out)) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== sv/ordered_list_engine_core.sv =====
`timescale 1ns / 1ps
// Top level of the ordered list engine: sequencer, length counter and cell chain.
// Depends on olist_pkg and olist_cell.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+-------------------------------
//   request | in_valid / in_stall     | req_type [1:0], value [31:0] signed
//   result  | out_valid / out_stall   | status [1:0], length [4:0], is_empty
//
// Each request goes through the transfer in the idle state, a match state in
// which every cell compares its entry with the key, and an apply state in which
// the first-match flag ripples down the cell chain and all cells shift at once.
// The result sits in an output register; a new request is taken while it waits,
// but the shift cycle holds until the result register is free.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
module ordered_list_engine_core #(
  parameter int MAX_ENTRIES = olist_pkg::DEF_MAX_ENTRIES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [olist_pkg::REQ_W-1:0]   req_type,
  input  logic signed [olist_pkg::DATA_W-1:0]  value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [olist_pkg::STAT_W-1:0]  status,
  output logic        [olist_pkg::LEN_W-1:0]   length,
  output logic                                 is_empty
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  olist_pkg::state_t               state, state_next;
  olist_pkg::req_t                 req;
  logic [olist_pkg::DATA_W-1:0]    key;
  logic [CNT_W-1:0]                count, count_next;
  olist_pkg::stat_t                stat_next;
  olist_pkg::cell_cmd_t            cmd;

  logic                            in_xfer;
  logic                            apply_go;
  logic                            full;
  logic                            empty;

  logic [MAX_ENTRIES-1:0][olist_pkg::DATA_W-1:0] entries;
  logic [MAX_ENTRIES:0]                          found_chain;

  assign in_stall = (state != olist_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  // Hold the shift cycle while an older result is still stalled.
  assign apply_go = (state == olist_pkg::ST_APPLY) && (!out_valid || !out_stall);
  assign full     = (count == CNT_W'(MAX_ENTRIES));
  assign empty    = (count == '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      olist_pkg::ST_IDLE:  if (in_xfer) state_next = olist_pkg::ST_MATCH;
      olist_pkg::ST_MATCH: state_next = olist_pkg::ST_APPLY;
      olist_pkg::ST_APPLY: if (apply_go) state_next = olist_pkg::ST_IDLE;
      default:             state_next = olist_pkg::ST_IDLE;
    endcase
  end

  // Cell commands
  always_comb begin
    cmd                  = '0;
    cmd.match_en         = (state == olist_pkg::ST_MATCH);
    cmd.load_tail        = apply_go && (req == olist_pkg::REQ_PUSH_BACK) && !full;
    cmd.shift_right      = apply_go && (req == olist_pkg::REQ_PUSH_FRONT) && !full;
    cmd.shift_left_all   = apply_go && (req == olist_pkg::REQ_POP_FRONT) && !empty;
    cmd.shift_left_found = apply_go && (req == olist_pkg::REQ_REMOVE);
  end

  // Status and new length
  always_comb begin
    stat_next  = olist_pkg::STAT_DONE;
    count_next = count;
    case (req)
      olist_pkg::REQ_PUSH_BACK, olist_pkg::REQ_PUSH_FRONT: begin
        if (full) stat_next = olist_pkg::STAT_FULL;
        else      count_next = count + 1'b1;
      end
      olist_pkg::REQ_POP_FRONT: begin
        if (empty) stat_next = olist_pkg::STAT_EMPTY;
        else       count_next = count - 1'b1;
      end
      olist_pkg::REQ_REMOVE: begin
        if (empty) begin
          stat_next = olist_pkg::STAT_EMPTY;
        end else if (found_chain[MAX_ENTRIES]) begin
          count_next = count - 1'b1;
        end else begin
          stat_next = olist_pkg::STAT_NOT_FOUND;
        end
      end
      default: stat_next = olist_pkg::STAT_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olist_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the request and load the result payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req <= olist_pkg::req_t'(req_type);
      key <= value;
    end
    if (apply_go) begin
      status   <= stat_next;
      length   <= olist_pkg::LEN_W'(count_next);
      is_empty <= (count_next == '0);
    end
  end

  // Cell chain: cell 0 is the front; the key enters at the front on push front.
  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [olist_pkg::DATA_W-1:0] left_w;
    logic [olist_pkg::DATA_W-1:0] right_w;

    if (i == 0) begin : g_front
      assign left_w = key;
    end else begin : g_mid_l
      assign left_w = entries[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_back
      assign right_w = entries[i];
    end else begin : g_mid_r
      assign right_w = entries[i+1];
    end

    olist_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .key         (key),
      .left_entry  (left_w),
      .right_entry (right_w),
      .occupied    (count > CNT_W'(i)),
      .is_tail     (count == CNT_W'(i)),
      .found_in    (found_chain[i]),
      .found_out   (found_chain[i+1]),
      .entry       (entries[i])
    );
  end

endmodule

// ===== tb/ordered_list_engine_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ordered_list_engine_core: random and directed list requests,
// checked per transfer against a queue-based shadow of the list. Depends on olist_pkg.
module ordered_list_engine_core_tb;

  localparam int CAPACITY       = olist_pkg::DEF_MAX_ENTRIES;
  localparam int RANDOM_ITEMS   = 520;
  localparam int STALL_PCT      = 26;
  localparam int HOLD_AT_RESULT = 100;  // start the long receiver hold-off here
  localparam int HOLD_CYCLES    = 80;
  localparam int QUIET_FROM     = 250;  // no idling on either side in this window
  localparam int QUIET_TO       = 350;
  localparam int DRAIN_CYCLES   = 10;
  localparam int STUCK_LIMIT    = 2000; // cycles without any transfer

  typedef struct {
    olist_pkg::req_t    kind;
    logic signed [31:0] val;
  } list_req_t;

  typedef struct {
    olist_pkg::stat_t st;
    logic [4:0]       len;
    logic             empty;
  } list_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [olist_pkg::REQ_W-1:0]    req_type = '0;
  logic signed [31:0]             value    = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [olist_pkg::STAT_W-1:0]   status;
  logic [olist_pkg::LEN_W-1:0]    length;
  logic                           is_empty;

  list_req_t          request_q[$];     // requests not yet offered
  list_reply_t        owed_replies[$];  // replies predicted, not yet seen
  logic signed [31:0] shadow_list[$];   // front of the list at index 0

  int        mismatch_count = 0;
  int        requests_taken = 0;
  int        replies_seen   = 0;
  int        stuck_cycles   = 0;
  int        hold_left      = 0;
  bit        hold_done      = 1'b0;
  list_req_t next_req;

  ordered_list_engine_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .length    (length),
    .is_empty  (is_empty)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one accepted request to the shadow list and return the reply it owes.
  function automatic list_reply_t list_apply(olist_pkg::req_t kind,
                                             logic signed [31:0] val);
    list_reply_t r;
    int          hit;
    r.st = olist_pkg::STAT_DONE;
    hit  = -1;
    case (kind)
      olist_pkg::REQ_PUSH_BACK, olist_pkg::REQ_PUSH_FRONT: begin
        if (shadow_list.size() >= CAPACITY) begin
          r.st = olist_pkg::STAT_FULL;  // drop the push, list unchanged
        end else if (kind == olist_pkg::REQ_PUSH_BACK) begin
          shadow_list.push_back(val);
        end else begin
          shadow_list.push_front(val);
        end
      end
      olist_pkg::REQ_POP_FRONT: begin
        if (shadow_list.size() == 0) begin
          r.st = olist_pkg::STAT_EMPTY;
        end else begin
          void'(shadow_list.pop_front());
        end
      end
      default: begin
        if (shadow_list.size() == 0) begin
          r.st = olist_pkg::STAT_EMPTY;
        end else begin
          // first match from the front, full 32-bit compare
          for (int i = 0; i < shadow_list.size() && hit < 0; i++) begin
            if (shadow_list[i] === val) hit = i;
          end
          if (hit < 0) begin
            r.st = olist_pkg::STAT_NOT_FOUND;
          end else begin
            shadow_list.delete(hit);
          end
        end
      end
    endcase
    r.len   = 5'(shadow_list.size());
    r.empty = (shadow_list.size() == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on reply %0d: %s got %0d, expected %0d",
             $realtime, replies_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_req(olist_pkg::req_t kind, logic signed [31:0] val);
    list_req_t q;
    q.kind = kind;
    q.val  = val;
    request_q.push_back(q);
  endtask

  // Stimulus and end of run.
  initial begin
    logic signed [31:0] pool[6];
    int                 made;
    int                 burst;
    int                 mode;
    int                 pick;
    int                 total;
    olist_pkg::req_t    kind;
    logic signed [31:0] v;

    // Directed part: empty-list pop and remove, value extremes, miss, middle
    // and duplicate removal, fill to capacity, then both pushes into a full list.
    add_req(olist_pkg::REQ_POP_FRONT, 32'sd0);
    add_req(olist_pkg::REQ_REMOVE, 32'sd0);
    add_req(olist_pkg::REQ_PUSH_BACK, 32'sh7FFF_FFFF);
    add_req(olist_pkg::REQ_PUSH_FRONT, 32'sh8000_0000);
    add_req(olist_pkg::REQ_PUSH_BACK, -32'sd1);
    add_req(olist_pkg::REQ_PUSH_BACK, 32'sd0);
    add_req(olist_pkg::REQ_REMOVE, 32'sd5);
    add_req(olist_pkg::REQ_REMOVE, -32'sd1);
    add_req(olist_pkg::REQ_POP_FRONT, 32'sh5A5A_5A5A);
    add_req(olist_pkg::REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
    add_req(olist_pkg::REQ_REMOVE, 32'sh7FFF_FFFF);
    add_req(olist_pkg::REQ_REMOVE, 32'sd0);  // tail entry
    for (int i = 0; i < 15; i++) begin
      add_req((i % 2) ? olist_pkg::REQ_PUSH_FRONT : olist_pkg::REQ_PUSH_BACK, $urandom());
    end
    add_req(olist_pkg::REQ_PUSH_BACK, 32'sd1);
    add_req(olist_pkg::REQ_PUSH_FRONT, 32'sd2);

    // Random part: bursts that lean toward filling, draining or neither, with
    // values drawn often from a small pool so removals find matches.
    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7FFF_FFFF;
    pool[2] = 32'sd0;
    pool[3] = -32'sd1;
    pool[4] = $urandom();
    pool[5] = $urandom();
    made = 0;
    while (made < RANDOM_ITEMS) begin
      burst = $urandom_range(50, 20);
      mode  = $urandom_range(2);
      for (int i = 0; i < burst && made < RANDOM_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (mode == 2) begin
          kind = olist_pkg::req_t'($urandom_range(3));
        end else if ((mode == 0 && pick < 75) || (mode == 1 && pick < 30)) begin
          kind = $urandom_range(1) ? olist_pkg::REQ_PUSH_FRONT : olist_pkg::REQ_PUSH_BACK;
        end else begin
          kind = $urandom_range(1) ? olist_pkg::REQ_REMOVE : olist_pkg::REQ_POP_FRONT;
        end
        v = ($urandom_range(99) < 50) ? pool[$urandom_range(5)] : $urandom();
        add_req(kind, v);
        made++;
      end
    end
    total = request_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Hold until every request has come back as a reply.
    while (replies_seen < total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Request driver: predict on each transfer, then offer the next request
  // unless idling. A stalled request stays put.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_replies.push_back(list_apply(olist_pkg::req_t'(req_type), value));
        requests_taken <= requests_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 &&
            ((requests_taken >= QUIET_FROM && requests_taken < QUIET_TO) ||
             $urandom_range(99) >= STALL_PCT)) begin
          next_req = request_q.pop_front();
          in_valid <= 1'b1;
          req_type <= next_req.kind;
          value    <= next_req.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: random stalls, one long hold-off so the block
  // fills up and stalls its input, and a window with no stalls at all.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && replies_seen >= HOLD_AT_RESULT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (replies_seen >= QUIET_FROM && replies_seen < QUIET_TO) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < STALL_PCT);
    end
  end

  // Reply monitor: compare each transfer with the oldest prediction.
  always @(posedge clk) begin
    list_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      replies_seen <= replies_seen + 1;
      if (owed_replies.size() == 0) begin
        report_mismatch("unpredicted reply", 1, 0);
      end else begin
        want = owed_replies.pop_front();
        if (status !== want.st)   report_mismatch("status", status, want.st);
        if (length !== want.len)  report_mismatch("length", length, want.len);
        if (is_empty !== want.empty) report_mismatch("is_empty", is_empty, want.empty);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, STUCK_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
sv/olist_pkg.sv
sv/olist_cell.sv
sv/ordered_list_engine_core.sv
tb/ordered_list_engine_core_tb.sv
